// File: design/checked_integer_alu_defines.svh
// Assertion macros used by the checker file.
`ifndef CHECKED_INTEGER_ALU_DEFINES_SVH
`define CHECKED_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CIA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CIA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/cia_pkg.sv
package cia_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_DIV_ZERO = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_FINISH
  } state_t;

  // command to the iterative unit
  typedef struct packed {
    logic start;
    logic is_div;
  } cmd_t;

endpackage

// File: design/cia_if.sv
interface cia_req_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [1:0]   req_type;
  logic [W-1:0] operand_a;
  logic [W-1:0] operand_b;
  logic         clear_error;

  modport source (output valid, req_type, operand_a, operand_b, clear_error, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, clear_error, output ready);
endinterface

interface cia_rsp_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] result_value;
  logic [1:0]   error_code;

  modport source (output valid, result_value, error_code, input ready);
  modport sink   (input valid, result_value, error_code, output ready);
endinterface

// File: design/cia_iter_unit.sv
// Shared shift-add multiplier / restoring divider on unsigned magnitudes.
// One bit per cycle, one adder for both.
module cia_iter_unit import cia_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  input  logic [W-1:0] mag_a,
  input  logic [W-1:0] mag_b,
  output logic         done,
  output logic [W-1:0] hi,
  output logic [W-1:0] lo
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic          busy;
  logic          is_div;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  mq;
  logic [W-1:0]  mb;

  logic [W+1:0]  add_x;
  logic [W+1:0]  add_y;
  logic [W+1:0]  sum;
  logic [W:0]    pp;
  logic          borrow;

  // single adder: add for multiply, subtract for divide
  always_comb begin
    add_x  = is_div ? {1'b0, acc, mq[W-1]} : {2'b00, acc};
    add_y  = {2'b00, mb};
    sum    = add_x + (is_div ? ~add_y : add_y) + (W+2)'(is_div);
    pp     = mq[0] ? sum[W:0] : {1'b0, acc};
    borrow = sum[W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      is_div <= cmd.is_div;
      cnt    <= CW'(W - 1);
      acc    <= '0;
      mq     <= mag_a;
      mb     <= mag_b;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (is_div) begin
        acc <= borrow ? {acc[W-2:0], mq[W-1]} : sum[W-1:0];
        mq  <= {mq[W-2:0], ~borrow};
      end else begin
        acc <= pp[W:1];
        mq  <= {pp[0], mq[W-1:1]};
      end
    end
  end

  assign hi = acc;
  assign lo = mq;

endmodule

// File: design/checked_integer_alu.sv
// Checked signed ALU, DATA_WIDTH-bit two's complement. Each request word
// asks for add, subtract, multiply or divide (truncating toward zero) and
// returns one response word with the result and a sticky error code
// (0 none, 1 overflow, 2 divide by zero). Any overflow or a zero divisor
// sets the error and returns 1; while the error stays set every result is 1
// and the code does not change. clear_error in a request clears the error
// before that request is worked. Add, subtract and every case decided up
// front (error pending, zero divisor, minimum divided by minus one) go from
// the start step straight to the finish step; multiply and divide first run
// through the shared shift-add / restoring-divide unit, which retires one
// bit per cycle. The request side is not ready while a request is being
// worked. The response sits in an output register, so a new request is
// taken while the previous response still waits; a request only stalls in
// its finish step when the response before it has not yet been taken.
module checked_integer_alu import cia_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input logic    clk,
  input logic    rst,
  cia_req_if.sink   req,
  cia_rsp_if.source rsp
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE      = W'(1);

  state_t state;
  state_t state_next;

  // working copy of the request
  op_t          op;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  err_t         err;          // sticky error, already cleared if requested

  logic         out_valid;
  logic [W-1:0] out_result;
  err_t         out_err;

  // unit interface
  cmd_t         cmd;
  logic         unit_done;
  logic [W-1:0] unit_hi;
  logic [W-1:0] unit_lo;

  // control
  logic         accept;
  logic         out_free;
  logic         load_out;
  logic         b_zero;
  logic         div_ovf;
  logic         use_unit;

  // finish-step results
  logic         sa;
  logic         sb;
  logic         neg;
  logic [W-1:0] addend;
  logic [W-1:0] sum;
  logic [W-1:0] limit;
  logic [W-1:0] lo_neg;
  logic [W-1:0] res_next;
  err_t         err_next;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // special divide cases, decided before the unit is started
  assign b_zero   = (b == '0);
  assign div_ovf  = (a == SIGN_BIT) && (b == '1);
  assign use_unit = (err == ERR_NONE) &&
                    ((op == OP_MUL) || ((op == OP_DIV) && !b_zero && !div_ovf));

  // request capture; magnitudes are taken here so the unit sees unsigned data
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= op_t'(req.req_type);
      a     <= req.operand_a;
      b     <= req.operand_b;
      mag_a <= req.operand_a[W-1] ? (~req.operand_a + ONE) : req.operand_a;
      mag_b <= req.operand_b[W-1] ? (~req.operand_b + ONE) : req.operand_b;
    end
  end

  // sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      err <= ERR_NONE;
    end else if (accept && req.clear_error) begin
      err <= ERR_NONE;
    end else if (load_out) begin
      err <= err_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_START;
      end
      ST_START: begin
        state_next = use_unit ? ST_RUN : ST_FINISH;
      end
      ST_RUN: begin
        if (unit_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // FSM outputs
  always_comb begin
    req.ready  = 1'b0;
    cmd.start  = 1'b0;
    cmd.is_div = (op == OP_DIV);
    load_out   = 1'b0;
    case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_START:  cmd.start = use_unit;
      ST_RUN:    ;
      ST_FINISH: load_out  = out_free;
      default:   ;
    endcase
  end

  cia_iter_unit #(.W(W)) u_unit (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .mag_a (mag_a),
    .mag_b (mag_b),
    .done  (unit_done),
    .hi    (unit_hi),
    .lo    (unit_lo)
  );

  // finish step: one add/subtract for add and sub, sign fixup for mul/div
  always_comb begin
    sa       = a[W-1];
    sb       = b[W-1];
    neg      = sa ^ sb;
    addend   = (op == OP_SUB) ? ~b : b;
    sum      = a + addend + W'(op == OP_SUB);
    limit    = neg ? SIGN_BIT : (SIGN_BIT - ONE);
    lo_neg   = ~unit_lo + ONE;
    res_next = ONE;
    err_next = err;
    if (err == ERR_NONE) begin
      case (op)
        OP_ADD: begin
          if ((sa == sb) && (sum[W-1] != sa)) err_next = ERR_OVERFLOW;
          else                                res_next = sum;
        end
        OP_SUB: begin
          if ((sa != sb) && (sum[W-1] != sa)) err_next = ERR_OVERFLOW;
          else                                res_next = sum;
        end
        OP_MUL: begin
          // product must fit the signed range for its sign
          if ((unit_hi != '0) || (unit_lo > limit)) err_next = ERR_OVERFLOW;
          else                                      res_next = neg ? lo_neg : unit_lo;
        end
        OP_DIV: begin
          if (b_zero)       err_next = ERR_DIV_ZERO;
          else if (div_ovf) err_next = ERR_OVERFLOW;
          else              res_next = neg ? lo_neg : unit_lo;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_result <= res_next;
      out_err    <= err_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_result;
  assign rsp.error_code   = out_err;

endmodule

// File: design/cia_checker.sv
`include "checked_integer_alu_defines.svh"

module cia_checker import cia_pkg::*; #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] result_value,
  input logic [1:0]   error_code
);

  localparam logic [W-1:0] ONE = W'(1);

  // stalled response word holds
  `CIA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(error_code), "stalled response changed")

  // only defined error codes leave the block
  `CIA_ASSERT_NOW(a_code_legal, clk, rst, out_valid, (error_code == ERR_NONE) || (error_code == ERR_OVERFLOW) || (error_code == ERR_DIV_ZERO), "undefined error code")

  // any error forces the result to one
  `CIA_ASSERT_NOW(a_err_result, clk, rst, out_valid && (error_code != ERR_NONE), result_value == ONE, "error without result of one")

  // one request at a time: busy right after a request is taken
  `CIA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule

bind checked_integer_alu cia_checker #(.W(DATA_WIDTH)) u_cia_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .result_value (rsp.result_value),
  .error_code   (rsp.error_code)
);

// File: sim/tb_top.sv
module tb_top;
  import cia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W              = 32;
  localparam int RANDOM_WORDS   = 700;
  // extra drain time after the last expected response has arrived
  localparam int DRAIN_CYCLES   = 2 * (W + 4);
  // longest legal quiet stretch is the long receiver hold plus one op, far below this
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 90;
  localparam int HOLD_AT_WORD   = 200;

  localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG1  = {W{1'b1}};
  localparam longint       L_MIN = -(64'sd1 <<< (W - 1));
  localparam longint       L_MAX = (64'sd1 <<< (W - 1)) - 1;

  typedef struct {
    logic [W-1:0] value;
    err_t         err;
  } alu_result_t;

  // one row of the directed part; pinned rows carry a hand-typed answer
  typedef struct {
    op_t          op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         clr;
    logic         pinned;
    alu_result_t  answer;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  cia_req_if #(.W(W)) req_ch ();
  cia_rsp_if #(.W(W)) rsp_ch ();

  checked_integer_alu #(.DATA_WIDTH(W)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #4 clk = ~clk;

  // predictor state: the sticky error as the block should hold it
  err_t        sticky_err;
  alu_result_t result_q[$];
  stim_row_t   stim_rows[$];

  int words_sent    = 0;
  int words_checked = 0;
  int error_count   = 0;
  int ovf_seen      = 0;
  int dz_seen       = 0;
  int idle_cycles   = 0;

  // Exact arithmetic in 64 bits, then a range check against W signed bits.
  // SV signed division already truncates toward zero.
  function automatic alu_result_t predict_alu(input op_t op, input logic [W-1:0] a,
                                              input logic [W-1:0] b, input logic clr);
    alu_result_t r;
    longint      sa;
    longint      sb;
    longint      exact;
    if (clr) sticky_err = ERR_NONE;
    r.value = 1;
    if (sticky_err == ERR_NONE) begin
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      exact = 0;
      case (op)
        OP_ADD: exact = sa + sb;
        OP_SUB: exact = sa - sb;
        OP_MUL: exact = sa * sb;
        OP_DIV: if (sb != 0) exact = sa / sb;
      endcase
      // min / -1 lands at 2^(W-1) and falls out as overflow here
      if (op == OP_DIV && sb == 0) sticky_err = ERR_DIV_ZERO;
      else if (exact > L_MAX || exact < L_MIN) sticky_err = ERR_OVERFLOW;
      else r.value = exact[W-1:0];
    end
    r.err = sticky_err;
    return r;
  endfunction

  // operand mix: corners, small values, values near the multiply boundary, full range
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = S_MIN;
          1:       v = S_MAX;
          2:       v = '0;
          3:       v = NEG1;
          default: v = 1;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 1000);
        if ($urandom_range(0, 1)) v = -v;
      end
      3, 4: begin
        v = $urandom_range(0, 32'h1_FFFF);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_row(input op_t op, input logic [W-1:0] a, input logic [W-1:0] b,
                         input logic clr, input logic pinned, input logic [W-1:0] value,
                         input err_t err);
    stim_row_t row;
    row.op           = op;
    row.a            = a;
    row.b            = b;
    row.clr          = clr;
    row.pinned       = pinned;
    row.answer.value = value;
    row.answer.err   = err;
    stim_rows.push_back(row);
  endtask

  // Offer one request word and return on the edge it is taken. valid is only
  // dropped when a gap is drawn, so back-to-back words keep it high.
  task automatic send_word(input stim_row_t row);
    int          gap;
    alu_result_t predicted;
    // every fifth stretch of 50 words goes out with no gaps
    gap = ((words_sent / 50) % 5 == 4) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= row.op;
    req_ch.operand_a   <= row.a;
    req_ch.operand_b   <= row.b;
    req_ch.clear_error <= row.clr;
    do @(posedge clk); while (!req_ch.ready);
    // predictor runs on every word so the sticky state tracks pinned rows too
    predicted = predict_alu(row.op, row.a, row.b, row.clr);
    result_q.push_back(row.pinned ? row.answer : predicted);
    words_sent++;
  endtask

  task automatic check_word();
    alu_result_t want;
    if (result_q.size() == 0) begin
      $display("%0t ns: response word with nothing expected, actual value %0d code %0d",
               $time, $signed(rsp_ch.result_value), rsp_ch.error_code);
      error_count++;
    end else begin
      want = result_q.pop_front();
      if (rsp_ch.result_value !== want.value) begin
        $display("%0t ns: result_value mismatch, expected %0d, actual %0d",
                 $time, $signed(want.value), $signed(rsp_ch.result_value));
        error_count++;
      end
      if (rsp_ch.error_code !== want.err) begin
        $display("%0t ns: error_code mismatch, expected %0d, actual %0d",
                 $time, want.err, rsp_ch.error_code);
        error_count++;
      end
    end
    if (rsp_ch.error_code == ERR_OVERFLOW) ovf_seen++;
    if (rsp_ch.error_code == ERR_DIV_ZERO) dz_seen++;
    words_checked++;
  endtask

  // Response side: random stall before each word, a few stall-free stretches,
  // and one long hold so the output register fills and the request side backs up.
  initial begin : response_side
    int stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (words_checked == HOLD_AT_WORD) stall = HOLD_CYCLES;
      else if ((words_checked / 40) % 4 == 2) stall = 0;
      else stall = $urandom_range(0, 3);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      check_word();
    end
  end

  // watchdog: cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d responses outstanding",
               $time, idle_cycles, result_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : request_side
    stim_row_t row;
    int        n_directed;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= OP_ADD;
    req_ch.operand_a   <= '0;
    req_ch.operand_b   <= '0;
    req_ch.clear_error <= 1'b0;
    sticky_err = ERR_NONE;

    // Directed rows. Pinned answers are the obvious ones: first word after
    // reset, corner overflows, error codes, a pending error returning 1.
    //       op      a             b             clr   pin   value         err
    add_row(OP_ADD, '0,           '0,           1'b0, 1'b1, '0,           ERR_NONE);
    add_row(OP_ADD, S_MAX,        32'd1,        1'b0, 1'b1, 32'd1,        ERR_OVERFLOW);
    // error still pending: result 1, code held
    add_row(OP_SUB, 32'd5,        32'd3,        1'b0, 1'b1, 32'd1,        ERR_OVERFLOW);
    add_row(OP_MUL, 32'd2,        32'd3,        1'b1, 1'b1, 32'd6,        ERR_NONE);
    add_row(OP_ADD, S_MIN,        NEG1,         1'b0, 1'b1, 32'd1,        ERR_OVERFLOW);
    add_row(OP_ADD, S_MAX,        S_MIN,        1'b1, 1'b1, NEG1,         ERR_NONE);
    add_row(OP_SUB, S_MIN,        32'd1,        1'b0, 1'b1, 32'd1,        ERR_OVERFLOW);
    add_row(OP_SUB, '0,           S_MIN,        1'b1, 1'b1, 32'd1,        ERR_OVERFLOW);
    add_row(OP_SUB, S_MAX,        S_MAX,        1'b1, 1'b1, '0,           ERR_NONE);
    add_row(OP_SUB, NEG1,         S_MAX,        1'b0, 1'b0, '0,           ERR_NONE);
    add_row(OP_MUL, S_MAX,        S_MAX,        1'b0, 1'b1, 32'd1,        ERR_OVERFLOW);
    add_row(OP_MUL, S_MIN,        NEG1,         1'b1, 1'b1, 32'd1,        ERR_OVERFLOW);
    add_row(OP_MUL, S_MIN,        32'd1,        1'b1, 1'b0, '0,           ERR_NONE);
    // product exactly at the negative limit, then one past the positive one
    add_row(OP_MUL, 32'hFFFF_0000, 32'h0000_8000, 1'b0, 1'b0, '0,         ERR_NONE);
    add_row(OP_MUL, 32'h0001_0000, 32'h0000_8000, 1'b0, 1'b0, '0,         ERR_NONE);
    add_row(OP_DIV, 32'd7,        '0,           1'b1, 1'b1, 32'd1,        ERR_DIV_ZERO);
    // zero by zero still counts as a zero divisor
    add_row(OP_DIV, '0,           '0,           1'b1, 1'b1, 32'd1,        ERR_DIV_ZERO);
    add_row(OP_DIV, 32'd9,        32'd3,        1'b0, 1'b1, 32'd1,        ERR_DIV_ZERO);
    add_row(OP_DIV, S_MIN,        NEG1,         1'b1, 1'b1, 32'd1,        ERR_OVERFLOW);
    add_row(OP_DIV, -32'sd7,      32'd2,        1'b1, 1'b0, '0,           ERR_NONE);
    add_row(OP_DIV, 32'd7,        -32'sd2,      1'b0, 1'b0, '0,           ERR_NONE);
    add_row(OP_DIV, S_MIN,        32'd1,        1'b0, 1'b0, '0,           ERR_NONE);
    add_row(OP_DIV, S_MAX,        S_MIN,        1'b0, 1'b0, '0,           ERR_NONE);
    add_row(OP_MUL, '0,           S_MIN,        1'b0, 1'b0, '0,           ERR_NONE);
    add_row(OP_DIV, S_MIN,        S_MIN,        1'b0, 1'b0, '0,           ERR_NONE);
    n_directed = stim_rows.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) send_word(stim_rows[i]);

    // Random words. Clear is set half the time so errors do not park the
    // block on the constant 1 result for long.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      row.op     = op_t'($urandom_range(0, 3));
      row.a      = pick_operand();
      row.b      = pick_operand();
      row.clr    = 1'($urandom_range(0, 1));
      row.pinned = 1'b0;
      row.answer = '{value: '0, err: ERR_NONE};
      send_word(row);
    end
    req_ch.valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request words (%0d directed, %0d random), checked %0d responses.",
             words_sent, n_directed, words_sent - n_directed, words_checked);
    $display("Responses carrying overflow: %0d, divide by zero: %0d, mismatches: %0d.",
             ovf_seen, dz_seen, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
